>>> src/lts_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Scan modes, token kind codes, error codes and character class helpers.
// ----------------------------------------------------------------------------
package lts_pkg;

  typedef enum logic [4:0] {
    M_IDLE, M_OP, M_SLASH, M_DOTP, M_NINT, M_NDOT, M_NFRAC, M_NEXP, M_NSIGN,
    M_NEXPD, M_IDENT, M_STR, M_STRESC, M_LCOM, M_BC, M_BCS, M_BCT
  } scan_mode_e;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_QUEST   = 6'd11;
  localparam logic [5:0] K_COLON   = 6'd12;
  localparam logic [5:0] K_BANG    = 6'd13;
  localparam logic [5:0] K_EQUAL   = 6'd15;
  localparam logic [5:0] K_GREATER = 6'd17;
  localparam logic [5:0] K_LESS    = 6'd19;
  localparam logic [5:0] K_IDENT   = 6'd21;
  localparam logic [5:0] K_STRING  = 6'd22;
  localparam logic [5:0] K_NUMBER  = 6'd23;
  localparam logic [5:0] K_KEY0    = 6'd24;
  localparam logic [5:0] K_BYTE    = 6'd41;
  localparam logic [5:0] K_ERROR   = 6'd42;
  localparam logic [5:0] K_END     = 6'd43;

  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_ESCAPE     = 3'd1;
  localparam logic [2:0] E_OPEN_STR   = 3'd2;
  localparam logic [2:0] E_EMPTY_EXP  = 3'd3;
  localparam logic [2:0] E_OPEN_COM   = 3'd4;
  localparam logic [2:0] E_UNEXPECTED = 3'd5;

  localparam int NumKw = 17;
  localparam logic [47:0] KW_TEXT [NumKw] = '{
    48'("and"), 48'("class"), 48'("else"), 48'("false"), 48'("for"),
    48'("fun"), 48'("if"), 48'("nil"), 48'("or"), 48'("print"),
    48'("return"), 48'("super"), 48'("this"), 48'("true"), 48'("var"),
    48'("while"), 48'("break")
  };

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "=":     k = K_EQUAL;
      ">":     k = K_GREATER;
      "<":     k = K_LESS;
      default: k = K_BANG;
    endcase
    return k;
  endfunction

endpackage

>>> src/lts_front.sv
// ----------------------------------------------------------------------------
// Token scanner front end
// Takes one source byte per cycle when take_i is set; forms up to three words.
// ----------------------------------------------------------------------------
module lts_front import lts_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int NEST_BITS   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 action_i,
  input  logic [7:0]           code_i,
  output logic                 wr_o,
  output logic [1:0]           wr_n_o,
  output logic [3*(6+8+2*OFFSET_BITS+LINE_BITS+COLUMN_BITS+3)-1:0] wr_res_o
);

  typedef struct packed {
    logic [5:0]             kind;
    logic [7:0]             byte_value;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [2:0]             err;
  } res_t;

  localparam logic [OFFSET_BITS-1:0] MaxOff  = '1;
  localparam logic [LINE_BITS-1:0]   MaxLine = '1;
  localparam logic [COLUMN_BITS-1:0] MaxCol  = '1;
  localparam logic [NEST_BITS-1:0]   MaxNest = '1;

  scan_mode_e             mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [47:0]            word_q, word_d;
  logic [2:0]             wcnt_q, wcnt_d;
  logic                   wlong_q, wlong_d;
  logic [NEST_BITS-1:0]   depth_q, depth_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, tstart_q, tstart_d, moff_q, moff_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, scol_q, scol_d, mcol_q, mcol_d;
  logic [OFFSET_BITS-1:0] old_pos;
  logic [COLUMN_BITS-1:0] old_col;
  logic                   acc;
  logic [1:0]             n;
  res_t [2:0]             res;
  logic [5:0]             wkind;
  logic [8:0]             dec;

  function automatic res_t mk(logic [5:0] k, logic [7:0] b, logic [OFFSET_BITS-1:0] s,
                              logic [OFFSET_BITS-1:0] p, logic [LINE_BITS-1:0] ln,
                              logic [COLUMN_BITS-1:0] cl, logic [2:0] e);
    res_t r;
    r.kind = k;
    r.byte_value = b;
    r.start = s;
    r.len = p - s;
    r.line = ln;
    r.column = cl;
    r.err = e;
    return r;
  endfunction

  always_comb begin
    wkind = K_IDENT;
    if (!wlong_q) begin
      for (int i = 0; i < NumKw; i++) begin
        if (word_q == KW_TEXT[i]) begin
          wkind = K_KEY0 + 6'(i);
        end
      end
    end
  end

  always_comb begin
    unique case (mode_q)
      M_OP:    acc = code_i == "=";
      M_SLASH: acc = code_i == "/" || code_i == "*";
      M_DOTP, M_NDOT, M_NSIGN, M_NEXPD: acc = is_digit(code_i);
      M_NINT:  acc = is_digit(code_i) || code_i == "." || code_i == "e" || code_i == "E";
      M_NFRAC: acc = is_digit(code_i) || code_i == "e" || code_i == "E";
      M_NEXP:  acc = is_digit(code_i) || code_i == "+" || code_i == "-";
      M_IDENT: acc = is_word(code_i);
      M_LCOM:  acc = code_i != 8'h0a;
      default: acc = 1'b1;
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    pend_d = pend_q;
    word_d = word_q;
    wcnt_d = wcnt_q;
    wlong_d = wlong_q;
    depth_d = depth_q;
    pos_d = pos_q;
    tstart_d = tstart_q;
    moff_d = moff_q;
    line_d = line_q;
    col_d = col_q;
    scol_d = scol_q;
    mcol_d = mcol_q;
    n = 2'd0;
    res = '0;
    old_pos = pos_q;
    old_col = col_q;
    dec = 9'h100;

    if (action_i || !acc) begin
      unique case (mode_q)
        M_OP: begin
          res[n] = mk(op_kind(pend_q), 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
        end
        M_SLASH: begin
          res[n] = mk(K_SLASH, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
        end
        M_DOTP: begin
          res[n] = mk(K_DOT, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
        end
        M_NINT, M_NFRAC, M_NEXPD: begin
          res[n] = mk(K_NUMBER, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
        end
        M_NDOT: begin
          res[n] = mk(K_NUMBER, 8'd0, tstart_d, moff_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
          tstart_d = moff_d;
          scol_d = mcol_d;
          res[n] = mk(K_DOT, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
        end
        M_NEXP, M_NSIGN: begin
          res[n] = mk(K_ERROR, 8'd0, tstart_d, pos_d, line_d, col_d, E_EMPTY_EXP);
          n = n + 2'd1;
        end
        M_IDENT: begin
          res[n] = mk(wkind, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
        end
        M_STR, M_STRESC: begin
          res[n] = mk(K_ERROR, 8'd0, tstart_d, pos_d, line_d, col_d, E_OPEN_STR);
          n = n + 2'd1;
        end
        M_BC, M_BCS, M_BCT: begin
          res[n] = mk(K_ERROR, 8'd0, tstart_d, pos_d, line_d, col_d, E_OPEN_COM);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      mode_d = M_IDLE;
    end

    if (action_i) begin
      res[n] = mk(K_END, 8'd0, pos_d, pos_d, line_d, scol_d, E_NONE);
      n = n + 2'd1;
      mode_d = M_IDLE;
      pend_d = 8'd0;
      word_d = '0;
      wcnt_d = 3'd0;
      wlong_d = 1'b0;
      depth_d = '0;
      pos_d = '0;
      tstart_d = '0;
      moff_d = '0;
      line_d = LINE_BITS'(1);
      col_d = COLUMN_BITS'(1);
      scol_d = COLUMN_BITS'(1);
      mcol_d = COLUMN_BITS'(1);
    end else begin
      old_pos = pos_d;
      old_col = col_d;
      if (mode_d == M_IDLE) begin
        tstart_d = pos_d;
        scol_d = col_d;
      end
      if (pos_d != MaxOff) pos_d = pos_d + 1'b1;
      if (code_i == 8'h0a) begin
        if (line_d != MaxLine) line_d = line_d + 1'b1;
        col_d = COLUMN_BITS'(1);
      end else if (col_d != MaxCol) begin
        col_d = col_d + 1'b1;
      end

      unique case (mode_d)
        M_IDLE: begin
          case (code_i)
            "(", ")", "{", "}", ",", "-", "+", ";", "*", "?", ":": begin
              case (code_i)
                "(":     res[n] = mk(K_LPAREN, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                ")":     res[n] = mk(K_RPAREN, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                "{":     res[n] = mk(K_LBRACE, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                "}":     res[n] = mk(K_RBRACE, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                ",":     res[n] = mk(K_COMMA, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                "-":     res[n] = mk(K_MINUS, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                "+":     res[n] = mk(K_PLUS, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                ";":     res[n] = mk(K_SEMI, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                "*":     res[n] = mk(K_STAR, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                "?":     res[n] = mk(K_QUEST, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
                default: res[n] = mk(K_COLON, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
              endcase
              n = n + 2'd1;
            end
            "!", "=", "<", ">": begin
              pend_d = code_i;
              mode_d = M_OP;
            end
            "/": mode_d = M_SLASH;
            ".": mode_d = M_DOTP;
            " ", 8'h0d, 8'h09, 8'h0a: begin
            end
            "\"": mode_d = M_STR;
            default: begin
              if (is_digit(code_i)) begin
                mode_d = M_NINT;
              end else if (is_alpha(code_i) || code_i == "_") begin
                word_d = {40'd0, code_i};
                wcnt_d = 3'd1;
                wlong_d = 1'b0;
                mode_d = M_IDENT;
              end else begin
                res[n] = mk(K_ERROR, code_i, tstart_d, pos_d, line_d, col_d, E_UNEXPECTED);
                n = n + 2'd1;
              end
            end
          endcase
        end
        M_OP: begin
          res[n] = mk(op_kind(pend_d) + 6'd1, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
          n = n + 2'd1;
          mode_d = M_IDLE;
        end
        M_SLASH: begin
          if (code_i == "/") begin
            mode_d = M_LCOM;
          end else begin
            depth_d = NEST_BITS'(1);
            mode_d = M_BC;
          end
        end
        M_DOTP: mode_d = M_NINT;
        M_NINT: begin
          if (code_i == ".") begin
            moff_d = old_pos;
            mcol_d = old_col;
            mode_d = M_NDOT;
          end else if (code_i == "e" || code_i == "E") begin
            mode_d = M_NEXP;
          end
        end
        M_NDOT: mode_d = M_NFRAC;
        M_NFRAC: begin
          if (code_i == "e" || code_i == "E") mode_d = M_NEXP;
        end
        M_NEXP: mode_d = is_digit(code_i) ? M_NEXPD : M_NSIGN;
        M_NSIGN: mode_d = M_NEXPD;
        M_NEXPD, M_LCOM: begin
        end
        M_IDENT: begin
          if (wcnt_d < 3'd6) begin
            word_d = {word_d[39:0], code_i};
            wcnt_d = wcnt_d + 3'd1;
          end else begin
            wlong_d = 1'b1;
          end
        end
        M_STR: begin
          if (code_i == "\"") begin
            res[n] = mk(K_STRING, 8'd0, tstart_d, pos_d, line_d, scol_d, E_NONE);
            n = n + 2'd1;
            mode_d = M_IDLE;
          end else if (code_i == "\\") begin
            mode_d = M_STRESC;
          end else begin
            res[n] = mk(K_BYTE, code_i, tstart_d, pos_d, line_d, scol_d, E_NONE);
            n = n + 2'd1;
          end
        end
        M_STRESC: begin
          case (code_i)
            "\"", "\\": dec = {1'b0, code_i};
            "n":        dec = 9'd10;
            "r":        dec = 9'd13;
            "t":        dec = 9'd9;
            default:    dec = 9'h100;
          endcase
          if (!dec[8]) begin
            res[n] = mk(K_BYTE, dec[7:0], tstart_d, pos_d, line_d, scol_d, E_NONE);
          end else begin
            res[n] = mk(K_ERROR, code_i, tstart_d, pos_d, line_d, col_d, E_ESCAPE);
          end
          n = n + 2'd1;
          mode_d = M_STR;
        end
        M_BC: begin
          if (code_i == "/") mode_d = M_BCS;
          else if (code_i == "*") mode_d = M_BCT;
        end
        M_BCS: begin
          if (code_i == "*") begin
            if (depth_d != MaxNest) depth_d = depth_d + 1'b1;
            mode_d = M_BC;
          end else if (code_i != "/") begin
            mode_d = M_BC;
          end
        end
        M_BCT: begin
          if (code_i == "/") begin
            if (depth_d != '0) depth_d = depth_d - 1'b1;
            mode_d = (depth_d == '0) ? M_IDLE : M_BC;
          end else if (code_i != "*") begin
            mode_d = M_BC;
          end
        end
        default: mode_d = M_IDLE;
      endcase
    end
  end

  assign wr_o = take_i && n != 2'd0;
  assign wr_n_o = n;
  assign wr_res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= 8'd0;
      word_q <= '0;
      wcnt_q <= 3'd0;
      wlong_q <= 1'b0;
      depth_q <= '0;
      pos_q <= '0;
      tstart_q <= '0;
      moff_q <= '0;
      line_q <= LINE_BITS'(1);
      col_q <= COLUMN_BITS'(1);
      scol_q <= COLUMN_BITS'(1);
      mcol_q <= COLUMN_BITS'(1);
    end else if (take_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      word_q <= word_d;
      wcnt_q <= wcnt_d;
      wlong_q <= wlong_d;
      depth_q <= depth_d;
      pos_q <= pos_d;
      tstart_q <= tstart_d;
      moff_q <= moff_d;
      line_q <= line_d;
      col_q <= col_d;
      scol_q <= scol_d;
      mcol_q <= mcol_d;
    end
  end

`ifndef SYNTH
  a_tstart_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tstart_q <= pos_q) else $error("token start beyond position");
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0 && col_q != '0) else $error("line or column at zero");
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && action_i |=> mode_q == M_IDLE && pos_q == '0)
    else $error("end marker did not reset the scanner");
`endif

endmodule

>>> src/lts_queue.sv
// ----------------------------------------------------------------------------
// Token scanner result queue
// Holds word bundles from the front end and hands them out one word at a time.
// ----------------------------------------------------------------------------
module lts_queue import lts_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  logic [1:0]             wr_n_i,
  input  logic [3*(6+8+2*OFFSET_BITS+LINE_BITS+COLUMN_BITS+3)-1:0] wr_res_i,
  output logic                   full_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [5:0]             kind_o,
  output logic [7:0]             byte_value_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] length_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] column_o,
  output logic [2:0]             error_code_o,
  output logic                   last_o
);

  typedef struct packed {
    logic [5:0]             kind;
    logic [7:0]             byte_value;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [2:0]             err;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t [2:0] res;
  } bundle_t;

  bundle_t    mem_q [4];
  logic [1:0] wp_q, wp_d, rp_q, rp_d, idx_q, idx_d;
  logic [2:0] cnt_q, cnt_d;
  bundle_t    head;
  res_t       cur;
  logic       take, done;

  assign head = mem_q[rp_q];
  assign cur = head.res[idx_q];
  assign full_o = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign last_o = idx_q == head.n - 2'd1;
  assign take = pop_i && !empty_o;
  assign done = take && last_o;

  assign kind_o = cur.kind;
  assign byte_value_o = cur.byte_value;
  assign start_offset_o = cur.start;
  assign length_o = cur.len;
  assign line_o = cur.line;
  assign column_o = cur.column;
  assign error_code_o = cur.err;

  always_comb begin
    wp_d = wr_i ? wp_q + 2'd1 : wp_q;
    rp_d = done ? rp_q + 2'd1 : rp_q;
    idx_d = done ? 2'd0 : (take ? idx_q + 2'd1 : idx_q);
    cnt_d = cnt_q + {2'd0, wr_i} - {2'd0, done};
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= {wr_n_i, wr_res_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 2'd0;
      rp_q <= 2'd0;
      idx_q <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4 && !(wr_i && full_o)) else $error("queue overflow");
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> idx_q < head.n) else $error("word index past bundle end");
  a_no_empty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> wr_n_i != 2'd0) else $error("empty bundle written");
`endif

endmodule

>>> src/lox_token_scanner.sv
// ----------------------------------------------------------------------------
// Token scanner top level
// Streaming lexical scanner: source bytes in, tokens, string bytes and errors out.
// ----------------------------------------------------------------------------
// The scanner takes one source byte (or the end marker) per cycle whenever
// full is low, and each byte yields zero to three result words in the same
// cycle, which enter a four-bundle queue; the result side hands out one word
// per cycle while pop is high, so the sustained byte rate is one per cycle as
// long as bytes average at most one result word each, and otherwise is set
// by the one-word result port draining the queue.
module lox_token_scanner import lts_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int NEST_BITS   = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   action_i,
  input  logic [7:0]             code_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [5:0]             kind_o,
  output logic [7:0]             byte_value_o,
  output logic [OFFSET_BITS-1:0] start_offset_o,
  output logic [OFFSET_BITS-1:0] length_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] column_o,
  output logic [2:0]             error_code_o,
  output logic                   last_o
);

  logic       take, wr;
  logic [1:0] wr_n;
  logic [3*(6+8+2*OFFSET_BITS+LINE_BITS+COLUMN_BITS+3)-1:0] wr_res;

  assign take = push && !full;

  lts_front #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS), .NEST_BITS(NEST_BITS)
  ) u_front (
    .clk_i, .rst_ni, .take_i(take), .action_i, .code_i,
    .wr_o(wr), .wr_n_o(wr_n), .wr_res_o(wr_res)
  );

  lts_queue #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
  ) u_queue (
    .clk_i, .rst_ni, .wr_i(wr), .wr_n_i(wr_n), .wr_res_i(wr_res),
    .full_o(full), .empty_o(empty), .pop_i(pop),
    .kind_o, .byte_value_o, .start_offset_o, .length_o, .line_o, .column_o,
    .error_code_o, .last_o
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token scanner testbench
// Sends source bytes and end markers into the scanner, predicts every
// token, decoded string byte and error word, and checks each result word
// field by field as it is popped. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench import lts_pkg::*; ();

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  bval;
    logic [23:0] start;
    logic [23:0] len;
    logic [19:0] line;
    logic [15:0] col;
    logic [2:0]  err;
    logic        last;
  } token_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        action = 1'b0;
  logic [7:0]  code = 8'd0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [5:0]  kind;
  logic [7:0]  byte_value;
  logic [23:0] start_offset, length;
  logic [19:0] line;
  logic [15:0] column;
  logic [2:0]  error_code;
  logic        last;

  token_word_t expected_words[$];
  token_word_t step_words[$];
  int          mismatches = 0;
  bit          no_idle = 1'b0;
  int          pop_wait = 0;
  int          pos_total = 0;

  scan_mode_e  mode;
  logic [7:0]  pend_op;
  logic [7:0]  wbuf [6];
  int          wcnt;
  logic        wlong;
  logic [7:0]  depth;
  logic [23:0] pos, tstart, mark_off;
  logic [19:0] ln;
  logic [15:0] colc, scol, mark_col;

  always #5 clk = ~clk;

  lox_token_scanner dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .action_i(action), .code_i(code), .empty(empty), .pop(pop),
    .kind_o(kind), .byte_value_o(byte_value), .start_offset_o(start_offset),
    .length_o(length), .line_o(line), .column_o(column),
    .error_code_o(error_code), .last_o(last)
  );

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit wordchar_c(logic [7:0] c);
    return alpha_c(c) || digit_c(c) || c == "_";
  endfunction

  function automatic logic [5:0] compare_kind(logic [7:0] c);
    case (c)
      "=": return K_EQUAL;
      ">": return K_GREATER;
      "<": return K_LESS;
      default: return K_BANG;
    endcase
  endfunction

  task automatic clear_scanner();
    mode = M_IDLE;
    pend_op = 8'd0;
    foreach (wbuf[i]) wbuf[i] = 8'd0;
    wcnt = 0;
    wlong = 1'b0;
    depth = 8'd0;
    pos = 24'd0;
    tstart = 24'd0;
    ln = 20'd1;
    colc = 16'd1;
    scol = 16'd1;
    mark_off = 24'd0;
    mark_col = 16'd1;
  endtask

  task automatic emit(logic [5:0] k, logic [7:0] b, logic [23:0] s, logic [23:0] l,
                      logic [15:0] c, logic [2:0] e);
    token_word_t w;
    if (step_words.size() < 3) begin
      w = '{kind: k, bval: b, start: s, len: l, line: ln, col: c, err: e, last: 1'b0};
      step_words = {step_words, w};
    end
  endtask

  task automatic emit_token(logic [5:0] k);
    emit(k, 8'd0, tstart, pos - tstart, scol, E_NONE);
  endtask

  task automatic emit_error(logic [2:0] e, logic [7:0] b);
    emit(K_ERROR, b, tstart, pos - tstart, colc, e);
  endtask

  function automatic logic [5:0] word_token();
    logic [47:0] w;
    w = '0;
    if (wlong || wcnt == 0) return K_IDENT;
    for (int i = 0; i < wcnt; i++) w = {w[39:0], wbuf[i]};
    for (int i = 0; i < NumKw; i++) begin
      if (KW_TEXT[i] == w) return K_KEY0 + 6'(i);
    end
    return K_IDENT;
  endfunction

  function automatic bit mode_takes(logic [7:0] c);
    case (mode)
      M_OP: return c == "=";
      M_SLASH: return c == "/" || c == "*";
      M_DOTP, M_NDOT, M_NSIGN, M_NEXPD: return digit_c(c);
      M_NINT: return digit_c(c) || c == "." || c == "e" || c == "E";
      M_NFRAC: return digit_c(c) || c == "e" || c == "E";
      M_NEXP: return digit_c(c) || c == "+" || c == "-";
      M_IDENT: return wordchar_c(c);
      M_LCOM: return c != 8'h0a;
      default: return 1'b1;
    endcase
  endfunction

  task automatic flush_pending();
    case (mode)
      M_OP: emit_token(compare_kind(pend_op));
      M_SLASH: emit_token(K_SLASH);
      M_DOTP: emit_token(K_DOT);
      M_NINT, M_NFRAC, M_NEXPD: emit_token(K_NUMBER);
      M_NDOT: begin
        emit(K_NUMBER, 8'd0, tstart, mark_off - tstart, scol, E_NONE);
        tstart = mark_off;
        scol = mark_col;
        emit_token(K_DOT);
      end
      M_NEXP, M_NSIGN: emit_error(E_EMPTY_EXP, 8'd0);
      M_IDENT: emit_token(word_token());
      M_STR, M_STRESC: emit_error(E_OPEN_STR, 8'd0);
      M_BC, M_BCS, M_BCT: emit_error(E_OPEN_COM, 8'd0);
      default: ;
    endcase
    mode = M_IDLE;
  endtask

  task automatic scan_from_idle(logic [7:0] c);
    case (c)
      "(": emit_token(K_LPAREN);
      ")": emit_token(K_RPAREN);
      "{": emit_token(K_LBRACE);
      "}": emit_token(K_RBRACE);
      ",": emit_token(K_COMMA);
      "-": emit_token(K_MINUS);
      "+": emit_token(K_PLUS);
      ";": emit_token(K_SEMI);
      "*": emit_token(K_STAR);
      "?": emit_token(K_QUEST);
      ":": emit_token(K_COLON);
      "!", "=", "<", ">": begin
        pend_op = c;
        mode = M_OP;
      end
      "/": mode = M_SLASH;
      ".": mode = M_DOTP;
      " ", 8'h0d, 8'h09, 8'h0a: ;
      "\"": mode = M_STR;
      default: begin
        if (digit_c(c)) begin
          mode = M_NINT;
        end else if (alpha_c(c) || c == "_") begin
          foreach (wbuf[i]) wbuf[i] = 8'd0;
          wbuf[0] = c;
          wcnt = 1;
          wlong = 1'b0;
          mode = M_IDENT;
        end else begin
          emit_error(E_UNEXPECTED, c);
        end
      end
    endcase
  endtask

  task automatic consume_byte(logic [7:0] c, logic [23:0] old_pos, logic [15:0] old_col);
    logic [8:0] d;
    case (mode)
      M_IDLE: scan_from_idle(c);
      M_OP: begin
        emit_token(compare_kind(pend_op) + 6'd1);
        mode = M_IDLE;
      end
      M_SLASH: begin
        if (c == "/") begin
          mode = M_LCOM;
        end else begin
          depth = 8'd1;
          mode = M_BC;
        end
      end
      M_DOTP: mode = M_NINT;
      M_NINT: begin
        if (c == ".") begin
          mark_off = old_pos;
          mark_col = old_col;
          mode = M_NDOT;
        end else if (c == "e" || c == "E") begin
          mode = M_NEXP;
        end
      end
      M_NDOT: mode = M_NFRAC;
      M_NFRAC: if (c == "e" || c == "E") mode = M_NEXP;
      M_NEXP: mode = digit_c(c) ? M_NEXPD : M_NSIGN;
      M_NSIGN: mode = M_NEXPD;
      M_NEXPD: ;
      M_IDENT: begin
        if (wcnt < 6) begin
          wbuf[wcnt] = c;
          wcnt++;
        end else begin
          wlong = 1'b1;
        end
      end
      M_STR: begin
        if (c == "\"") begin
          emit_token(K_STRING);
          mode = M_IDLE;
        end else if (c == "\\") begin
          mode = M_STRESC;
        end else begin
          emit(K_BYTE, c, tstart, pos - tstart, scol, E_NONE);
        end
      end
      M_STRESC: begin
        d = 9'h100;
        if (c == "\"" || c == "\\") d = {1'b0, c};
        else if (c == "n") d = 9'd10;
        else if (c == "r") d = 9'd13;
        else if (c == "t") d = 9'd9;
        if (!d[8]) emit(K_BYTE, d[7:0], tstart, pos - tstart, scol, E_NONE);
        else emit_error(E_ESCAPE, c);
        mode = M_STR;
      end
      M_LCOM: ;
      M_BC: begin
        if (c == "/") mode = M_BCS;
        else if (c == "*") mode = M_BCT;
      end
      M_BCS: begin
        if (c == "*") begin
          if (depth != 8'hff) depth++;
          mode = M_BC;
        end else if (c != "/") begin
          mode = M_BC;
        end
      end
      M_BCT: begin
        if (c == "/") begin
          if (depth > 0) depth--;
          mode = (depth == 0) ? M_IDLE : M_BC;
        end else if (c != "*") begin
          mode = M_BC;
        end
      end
      default: mode = M_IDLE;
    endcase
  endtask

  task automatic predict_scan(logic a, logic [7:0] c);
    logic [23:0] old_pos;
    logic [15:0] old_col;
    step_words.delete();
    if (a) begin
      flush_pending();
      emit(K_END, 8'd0, pos, 24'd0, scol, E_NONE);
      clear_scanner();
    end else begin
      if (!mode_takes(c)) flush_pending();
      old_pos = pos;
      old_col = colc;
      if (mode == M_IDLE) begin
        tstart = pos;
        scol = colc;
      end
      if (pos != 24'hffffff) pos++;
      if (c == 8'h0a) begin
        if (ln != 20'hfffff) ln++;
        colc = 16'd1;
      end else if (colc != 16'hffff) begin
        colc++;
      end
      consume_byte(c, old_pos, old_col);
    end
    if (step_words.size() > 0) step_words[$].last = 1'b1;
    foreach (step_words[i]) expected_words = {expected_words, step_words[i]};
  endtask

  task automatic send_word(logic a, logic [7:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    action <= a;
    code <= c;
    do @(posedge clk); while (full);
    predict_scan(a, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  task automatic send_end();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word kind %0d, nothing expected", $time, kind);
        end else begin
          token_word_t w;
          w = expected_words.pop_front();
          if (w != {kind, byte_value, start_offset, length, line, column, error_code, last}) begin
            mismatches++;
            $display("%0t: expected kind %0d byte %0d start %0d len %0d line %0d col %0d err %0d last %0d",
                     $time, w.kind, w.bval, w.start, w.len, w.line, w.col, w.err, w.last);
            $display("%0t: actual   kind %0d byte %0d start %0d len %0d line %0d col %0d err %0d last %0d",
                     $time, kind, byte_value, start_offset, length, line, column, error_code, last);
          end
        end
        pop_wait = no_idle ? 0 : $urandom_range(0, 5);
      end else if (pop_wait > 0) begin
        pop_wait--;
      end
      pop <= (pop_wait == 0);
    end
  end

  task automatic test_punctuation();
    send_text("(){},-+;*?:!!====<<=>>=/.");
    send_end();
  endtask

  task automatic test_numbers();
    send_text(".5 3.x 1e5 1.5E-2 1e;");
    send_end();
    send_text("7.");
    send_end();
    send_text("8e-");
    send_end();
  endtask

  task automatic test_words();
    send_text("and class return while break returned _x9\n");
    send_end();
  endtask

  task automatic test_strings_comments();
    send_text("\"a\\n\\q\" //c\n/*/**/*/");
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h80);
    send_text("\"x");
    send_end();
    send_text("/*");
    send_end();
    send_end();
  endtask

  task automatic send_random_fragment();
    int pick, n;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: send_word(1'b0, 8'($urandom_range("a", "z")));
            1: send_word(1'b0, 8'($urandom_range("A", "Z")));
            2: send_word(1'b0, 8'($urandom_range("0", "9")));
            default: send_word(1'b0, "_");
          endcase
        end
      end
      3, 4: begin
        n = $urandom_range(0, NumKw - 1);
        for (int b = 5; b >= 0; b--) begin
          if (KW_TEXT[n][b*8 +: 8] != 8'd0) send_word(1'b0, KW_TEXT[n][b*8 +: 8]);
        end
      end
      5, 6, 7: begin
        if ($urandom_range(0, 3) == 0) send_word(1'b0, ".");
        n = $urandom_range(1, 3);
        repeat (n) send_word(1'b0, 8'($urandom_range("0", "9")));
        if ($urandom_range(0, 1)) begin
          send_word(1'b0, ".");
          n = $urandom_range(0, 2);
          repeat (n) send_word(1'b0, 8'($urandom_range("0", "9")));
        end
        if ($urandom_range(0, 2) == 0) begin
          send_word(1'b0, $urandom_range(0, 1) ? "e" : "E");
          if ($urandom_range(0, 1)) send_word(1'b0, $urandom_range(0, 1) ? "+" : "-");
          n = $urandom_range(0, 2);
          repeat (n) send_word(1'b0, 8'($urandom_range("0", "9")));
        end
      end
      8, 9, 10: begin
        send_word(1'b0, "\"");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_word(1'b0, "\\");
            case ($urandom_range(0, 6))
              0: send_word(1'b0, "n");
              1: send_word(1'b0, "r");
              2: send_word(1'b0, "t");
              3: send_word(1'b0, "\"");
              4: send_word(1'b0, "\\");
              default: send_word(1'b0, 8'($urandom_range(0, 255)));
            endcase
          end else begin
            send_word(1'b0, 8'($urandom_range(0, 255)));
          end
        end
        if ($urandom_range(0, 5) != 0) send_word(1'b0, "\"");
      end
      11, 12, 13: begin
        case ($urandom_range(0, 6))
          0: send_word(1'b0, "!");
          1: send_word(1'b0, "=");
          2: send_word(1'b0, "<");
          3: send_word(1'b0, ">");
          4: send_word(1'b0, "/");
          5: send_word(1'b0, ".");
          default: send_word(1'b0, 8'($urandom_range("(", "-")));
        endcase
        if ($urandom_range(0, 1)) send_word(1'b0, "=");
      end
      14: begin
        if ($urandom_range(0, 1)) begin
          send_text("//");
          n = $urandom_range(0, 4);
          repeat (n) send_word(1'b0, 8'($urandom_range(0, 255)));
          send_word(1'b0, 8'h0a);
        end else begin
          send_text("/*");
          n = $urandom_range(0, 6);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: send_word(1'b0, "/");
              1: send_word(1'b0, "*");
              default: send_word(1'b0, 8'($urandom_range(0, 255)));
            endcase
          end
          if ($urandom_range(0, 3) != 0) send_text("*/");
        end
      end
      15, 16, 17: begin
        case ($urandom_range(0, 3))
          0: send_word(1'b0, " ");
          1: send_word(1'b0, 8'h0a);
          2: send_word(1'b0, 8'h09);
          default: send_word(1'b0, 8'h0d);
        endcase
      end
      18: send_word(1'b0, 8'($urandom_range(0, 255)));
      default: send_end();
    endcase
  endtask

  task automatic test_random(int count);
    int sent_before;
    sent_before = pos_total;
    while (pos_total - sent_before < count) begin
      if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
      send_random_fragment();
    end
    no_idle = 1'b0;
    send_end();
  endtask

  always @(posedge clk) if (push && !full && rst_n) pos_total <= pos_total + 1;

  initial begin
    clear_scanner();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_punctuation();
    test_numbers();
    wait_drained();
    test_words();
    test_strings_comments();
    wait_drained();
    test_random(8);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
